/* src/pgu_pkg.sv */
// Shared types, constants and helpers for the PBIL generation update block.
// Used by every module under src; depends on nothing.
package pgu_pkg;

  localparam int MAX_BITS   = 64;
  localparam int MAX_SEL    = 64;
  localparam int IDX_W      = 6;
  localparam int CNT_W      = 7;
  localparam int PROB_W     = 16;
  localparam int SCORE_W    = 7;
  localparam int LEN_W      = 7;
  localparam int DIV_W      = 23;
  localparam int DIVISOR_W  = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_STRING_LENGTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_RATE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SELECTED_COUNT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER_BORDER   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_FITNESS = 3'd4;

  localparam logic [6:0]  RST_STRING_LENGTH  = 7'd64;
  localparam logic [15:0] RST_LEARNING_RATE  = 16'd6554;
  localparam logic [6:0]  RST_SELECTED_COUNT = 7'd8;
  localparam logic [14:0] RST_LOWER_BORDER   = 15'd1024;
  localparam logic [6:0]  RST_TARGET_FITNESS = 7'd96;

  localparam logic [PROB_W-1:0] PROB_HALF = 16'd32768;

  typedef enum logic [3:0] {
    S_IDLE, S_SCORE, S_CMP, S_POS, S_INS, S_CNT_RD, S_CNT_ACC,
    S_P_RD, S_P_MUL, S_DIV, S_P_WR, S_P_OUT
  } state_t;

  typedef struct packed {
    logic cap;
    logic score;
    logic cmp;
    logic pos;
    logic ins;
    logic cnt_clr;
    logic cnt_rd;
    logic cnt_acc;
    logic p_rd;
    logic p_mul;
    logic p_wr;
    logic next_bit;
    logic gen_end;
  } cmd_t;

  typedef struct packed {
    logic final_cand;
    logic cnt_last;
    logic div_done;
    logic out_fire;
    logic bit_last;
  } stat_t;

  // Leading-blocks fitness: run of 11 pairs scores 3 each, the stopping
  // pair scores 1 (mixed) or 2 (00).
  function automatic logic [SCORE_W-1:0] leading_blocks(input logic [MAX_BITS-1:0] s,
                                                        input logic [LEN_W-1:0] len);
    logic [5:0] npairs;
    logic [5:0] n;
    logic [SCORE_W-1:0] f;
    npairs = len[6:1];
    n = 6'd32;
    for (int k = MAX_BITS/2 - 1; k >= 0; k--) begin
      if ((6'(k) >= npairs) || !(s[2*k] && s[2*k+1])) n = 6'(k);
    end
    if (n >= npairs) begin
      f = SCORE_W'(3 * npairs);
    end else if (s[{n[4:0], 1'b0}] || s[{n[4:0], 1'b1}]) begin
      f = SCORE_W'(3 * n + 1);
    end else begin
      f = SCORE_W'(3 * n + 2);
    end
    return f;
  endfunction

endpackage

/* src/pgu_divider.sv */
// Restoring divider, one quotient bit per cycle, for the eta*count/mu term.
// Depends on pgu_pkg.
module pgu_divider (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [pgu_pkg::DIV_W-1:0]      dividend,
  input  logic [pgu_pkg::DIVISOR_W-1:0]  divisor,
  output logic                           done,
  output logic [pgu_pkg::DIV_W-1:0]      quotient
);
  import pgu_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [4:0]           step_r, step_nxt;
  logic [DIV_W-1:0]     quo_r, quo_nxt;
  logic [DIVISOR_W-1:0] rem_r, rem_nxt;
  logic [DIVISOR_W-1:0] dsr_r, dsr_nxt;
  logic [DIVISOR_W:0]   trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    trial    = {rem_r, quo_r[DIV_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = 5'(DIV_W - 1);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = DIVISOR_W'(trial - {1'b0, dsr_r});
        quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = DIVISOR_W'(trial);
        quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
      end
      if (step_r == 5'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        step_nxt = step_r - 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    dsr_r  <= dsr_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

/* src/pgu_datapath.sv */
// Datapath: config registers, ranked store, column counters, probability
// memory, update arithmetic and output register. Depends on pgu_pkg, pgu_divider.
module pgu_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  pgu_pkg::cmd_t                   cmd,
  output pgu_pkg::stat_t                  stat,
  input  logic                            cfg_valid,
  input  logic [pgu_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pgu_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [63:0]                     in_candidate_bits,
  input  logic                            in_final_candidate,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [5:0]                      out_bit_index,
  output logic [15:0]                     out_probability,
  output logic [6:0]                      out_best_score,
  output logic                            out_reached_target,
  output logic                            out_model_end
);
  import pgu_pkg::*;

  // configuration
  logic [6:0]  string_length_r;
  logic [15:0] learning_rate_r;
  logic [6:0]  selected_count_r;
  logic [14:0] lower_border_r;
  logic [6:0]  target_fitness_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      string_length_r  <= RST_STRING_LENGTH;
      learning_rate_r  <= RST_LEARNING_RATE;
      selected_count_r <= RST_SELECTED_COUNT;
      lower_border_r   <= RST_LOWER_BORDER;
      target_fitness_r <= RST_TARGET_FITNESS;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_STRING_LENGTH:  string_length_r  <= cfg_data[6:0];
        CFG_LEARNING_RATE:  learning_rate_r  <= cfg_data;
        CFG_SELECTED_COUNT: selected_count_r <= cfg_data[6:0];
        CFG_LOWER_BORDER:   lower_border_r   <= cfg_data[14:0];
        CFG_TARGET_FITNESS: target_fitness_r <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  logic [LEN_W-1:0] len_eff;
  logic [6:0]       mu_eff;
  logic [16:0]      lb_eff, ub_eff;

  always_comb begin
    if (string_length_r < 7'd2)                  len_eff = 7'd2;
    else if (string_length_r > 7'(MAX_BITS))     len_eff = 7'(MAX_BITS);
    else                                         len_eff = {string_length_r[6:1], 1'b0};
    if (selected_count_r < 7'd1)                 mu_eff = 7'd1;
    else if (selected_count_r > 7'(MAX_SEL))     mu_eff = 7'(MAX_SEL);
    else                                         mu_eff = selected_count_r;
    lb_eff = (lower_border_r == 15'd0) ? 17'd1 : {2'b00, lower_border_r};
    ub_eff = 17'h10000 - lb_eff;
  end

  // ranked store: scores and slot pointers in rank order, strings by slot
  logic [SCORE_W-1:0]  score_r [MAX_SEL];
  logic [IDX_W-1:0]    slot_r  [MAX_SEL];
  logic [MAX_BITS-1:0] str_mem [MAX_SEL];
  logic [MAX_BITS-1:0] str_q;
  logic [6:0]          fill_r;
  logic [6:0]          fill_eff, top;
  logic                ins_ok;
  logic [IDX_W-1:0]    new_slot;

  logic [MAX_BITS-1:0] cand_r;
  logic                final_r;
  logic [SCORE_W-1:0]  sc_r;
  logic [MAX_SEL-1:0]  gt_r, gt_nxt;
  logic [6:0]          pos_r, pos_nxt;

  assign fill_eff = (fill_r < mu_eff) ? fill_r : mu_eff;
  assign top      = (fill_eff < mu_eff) ? fill_eff : mu_eff - 7'd1;
  assign ins_ok   = pos_r < mu_eff;
  assign new_slot = slot_r[top[IDX_W-1:0]];

  always_comb begin
    for (int j = 0; j < MAX_SEL; j++) begin
      gt_nxt[j] = (7'(j) < fill_eff) && (score_r[j] > sc_r);
    end
    pos_nxt = 7'(MAX_SEL);
    for (int j = MAX_SEL - 1; j >= 0; j--) begin
      if (!gt_r[j]) pos_nxt = 7'(j);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      cand_r  <= in_candidate_bits;
      final_r <= in_final_candidate;
    end
    if (cmd.score) sc_r <= leading_blocks(cand_r, len_eff);
    if (cmd.cmp)   gt_r <= gt_nxt;
    if (cmd.pos)   pos_r <= pos_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.ins && ins_ok) begin
      if (pos_r == 7'd0) score_r[0] <= sc_r;
      for (int j = 1; j < MAX_SEL; j++) begin
        if (7'(j) == pos_r)                          score_r[j] <= sc_r;
        else if ((7'(j) > pos_r) && (7'(j) <= top))  score_r[j] <= score_r[j-1];
      end
      str_mem[new_slot] <= cand_r;
    end
  end

  // slot pointers stay a permutation so a pushed-out slot is reused
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < MAX_SEL; j++) slot_r[j] <= IDX_W'(j);
    end else if (cmd.ins && ins_ok) begin
      if (pos_r == 7'd0) slot_r[0] <= new_slot;
      for (int j = 1; j < MAX_SEL; j++) begin
        if (7'(j) == pos_r)                          slot_r[j] <= new_slot;
        else if ((7'(j) > pos_r) && (7'(j) <= top))  slot_r[j] <= slot_r[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (cmd.gen_end) begin
      fill_r <= '0;
    end else if (cmd.ins) begin
      fill_r <= (ins_ok && (fill_eff < mu_eff)) ? fill_eff + 7'd1 : fill_eff;
    end
  end

  // column counting over the stored entries, then a shift line per bit
  logic [CNT_W-1:0] cnt_r [MAX_BITS];
  logic [6:0]       j_r;
  logic [6:0]       i_r;

  always_ff @(posedge clk) begin
    if (cmd.cnt_rd) str_q <= str_mem[slot_r[j_r[IDX_W-1:0]]];
  end

  always_ff @(posedge clk) begin
    if (cmd.cnt_clr) begin
      for (int b = 0; b < MAX_BITS; b++) cnt_r[b] <= '0;
      j_r <= '0;
      i_r <= '0;
    end else if (cmd.cnt_acc) begin
      for (int b = 0; b < MAX_BITS; b++) cnt_r[b] <= cnt_r[b] + CNT_W'(str_q[b]);
      j_r <= j_r + 7'd1;
    end else if (cmd.next_bit) begin
      for (int b = 0; b < MAX_BITS - 1; b++) cnt_r[b] <= cnt_r[b+1];
      cnt_r[MAX_BITS-1] <= '0;
      i_r <= i_r + 7'd1;
    end
  end

  // probability memory, entries without a valid bit read as one half
  logic [PROB_W-1:0] prob_mem [MAX_BITS];
  logic [MAX_BITS-1:0] prob_vld_r;
  logic [PROB_W-1:0] prob_q, p_r, p_new;
  logic              pvld_q;
  logic [31:0]       ep_r;
  logic [DIV_W-1:0]  quot;
  logic              div_done;
  logic [17:0]       p_sum;

  always_ff @(posedge clk) begin
    if (cmd.p_rd) begin
      prob_q <= prob_mem[i_r[IDX_W-1:0]];
      pvld_q <= prob_vld_r[i_r[IDX_W-1:0]];
    end
    if (cmd.p_mul) begin
      p_r  <= pvld_q ? prob_q : PROB_HALF;
      ep_r <= learning_rate_r * (pvld_q ? prob_q : PROB_HALF);
    end
    if (cmd.p_wr) prob_mem[i_r[IDX_W-1:0]] <= p_new;
  end

  always_ff @(posedge clk) begin
    if (!rst_n)         prob_vld_r <= '0;
    else if (cmd.p_wr)  prob_vld_r[i_r[IDX_W-1:0]] <= 1'b1;
  end

  pgu_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.p_mul),
    .dividend (DIV_W'({7'd0, learning_rate_r} * {16'd0, cnt_r[0]})),
    .divisor  (mu_eff),
    .done     (div_done),
    .quotient (quot)
  );

  always_comb begin
    p_sum = {2'b00, p_r} - {2'b00, ep_r[31:16]} + {2'b00, quot[15:0]};
    if (p_sum < {1'b0, lb_eff})       p_new = PROB_W'(lb_eff);
    else if (p_sum > {1'b0, ub_eff})  p_new = PROB_W'(ub_eff);
    else                              p_new = PROB_W'(p_sum);
  end

  // output register
  logic       out_valid_r;
  logic       out_fire;
  logic [6:0] best;

  assign out_fire = out_valid_r && out_ready;
  assign best     = (fill_r != 7'd0) ? score_r[0] : 7'd0;

  always_ff @(posedge clk) begin
    if (!rst_n)             out_valid_r <= 1'b0;
    else if (cmd.p_wr)      out_valid_r <= 1'b1;
    else if (out_fire)      out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.p_wr) begin
      out_bit_index      <= i_r[IDX_W-1:0];
      out_probability    <= p_new;
      out_best_score     <= best;
      out_reached_target <= (best == target_fitness_r);
      out_model_end      <= (i_r + 7'd1 == len_eff);
    end
  end

  assign out_valid       = out_valid_r;
  assign stat.final_cand = final_r;
  assign stat.cnt_last   = (j_r + 7'd1 >= fill_r);
  assign stat.div_done   = div_done;
  assign stat.out_fire   = out_fire;
  assign stat.bit_last   = (i_r + 7'd1 >= len_eff);

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= 7'(MAX_SEL)) else $error("ranked fill exceeds store depth");
  a_rank_order: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r >= 7'd2) |-> (score_r[0] >= score_r[1])) else $error("ranked store out of order");
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.p_wr |=> out_valid_r) else $error("updated probability not presented");
`endif

endmodule

/* src/pgu_ctrl.sv */
// Controller state machine: sequences scoring, ranked insertion, counting
// and the per-bit update. Depends on pgu_pkg.
module pgu_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output pgu_pkg::cmd_t  cmd,
  input  pgu_pkg::stat_t stat
);
  import pgu_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:    if (in_valid) state_nxt = S_SCORE;
      S_SCORE:   state_nxt = S_CMP;
      S_CMP:     state_nxt = S_POS;
      S_POS:     state_nxt = S_INS;
      S_INS:     state_nxt = stat.final_cand ? S_CNT_RD : S_IDLE;
      S_CNT_RD:  state_nxt = S_CNT_ACC;
      S_CNT_ACC: state_nxt = stat.cnt_last ? S_P_RD : S_CNT_RD;
      S_P_RD:    state_nxt = S_P_MUL;
      S_P_MUL:   state_nxt = S_DIV;
      S_DIV:     if (stat.div_done) state_nxt = S_P_WR;
      S_P_WR:    state_nxt = S_P_OUT;
      S_P_OUT:   if (stat.out_fire) state_nxt = stat.bit_last ? S_IDLE : S_P_RD;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.cap  = in_valid;
      end
      S_SCORE:   cmd.score = 1'b1;
      S_CMP:     cmd.cmp = 1'b1;
      S_POS:     cmd.pos = 1'b1;
      S_INS: begin
        cmd.ins     = 1'b1;
        cmd.cnt_clr = stat.final_cand;
      end
      S_CNT_RD:  cmd.cnt_rd = 1'b1;
      S_CNT_ACC: cmd.cnt_acc = 1'b1;
      S_P_RD:    cmd.p_rd = 1'b1;
      S_P_MUL:   cmd.p_mul = 1'b1;
      S_DIV:     ;
      S_P_WR:    cmd.p_wr = 1'b1;
      S_P_OUT: begin
        cmd.next_bit = stat.out_fire && !stat.bit_last;
        cmd.gen_end  = stat.out_fire && stat.bit_last;
      end
      default:   ;
    endcase
  end

endmodule

/* src/pbil_generation_update.sv */
// Top level of the PBIL generation update block.
// Depends on pgu_pkg, pgu_ctrl, pgu_datapath (and pgu_divider below it).
//
// Usage:
//  - Input channel (in_valid/in_ready): one candidate string per transaction,
//    in_final_candidate marks the last of a generation.
//  - A candidate is accepted in the idle state: the accepting cycle captures
//    it, then score, compare against the ranked scores, locate rank, insert;
//    in_ready returns after the insert, or after the whole update on a final one.
//    The ranked scores sit in flip-flops; strings sit in a slot memory.
//  - On a final candidate the block counts ones per column over the stored
//    entries (a read and an accumulate state per entry, through the single string
//    memory read port) and then updates one bit position at a time: read,
//    multiply, a restoring divide by mu (23 quotient steps, then a registered
//    done flag), write, present.
//  - Output channel (out_valid/out_ready): one transaction per bit position
//    in use, bit 0 first, model_end on the last. The next position is not
//    started until the current result has been taken, so a stalled receiver
//    simply holds the block.
//  - Config channel (cfg_valid/cfg_ready) is always ready; write only while
//    the block is idle. Unknown indices are ignored.
//  - Reset (rst_n low, synchronous): registers to defaults, store empty,
//    every probability reads as one half. No clearing pass is needed.
module pbil_generation_update (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [63:0]                     in_candidate_bits,
  input  logic                            in_final_candidate,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [5:0]                      out_bit_index,
  output logic [15:0]                     out_probability,
  output logic [6:0]                      out_best_score,
  output logic                            out_reached_target,
  output logic                            out_model_end,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pgu_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pgu_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import pgu_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // config writes go straight into the registers, never back-pressured
  assign cfg_ready = 1'b1;

  pgu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  pgu_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .cfg_valid          (cfg_valid),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_candidate_bits  (in_candidate_bits),
    .in_final_candidate (in_final_candidate),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_bit_index      (out_bit_index),
    .out_probability    (out_probability),
    .out_best_score     (out_best_score),
    .out_reached_target (out_reached_target),
    .out_model_end      (out_model_end)
  );

endmodule

/* dv/tb_top.sv */
// Self-checking bench for pbil_generation_update: drives candidate generations,
// predicts the updated probability vector and checks every result transaction.
// Depends on pgu_pkg and the RTL under src.

class pbil_scoreboard;
  // predictor state
  logic [63:0] store_bits[64];
  logic [6:0]  store_score[64];
  int unsigned store_fill;
  logic [15:0] probs[64];
  // register copies
  logic [6:0]  reg_len;
  logic [15:0] reg_eta;
  logic [6:0]  reg_mu;
  logic [14:0] reg_lb;
  logic [6:0]  reg_target;
  // expected result transactions
  logic [30:0] pending_results[$];
  int unsigned errors;

  function new();
    store_fill = 0;
    errors = 0;
    for (int i = 0; i < 64; i++) probs[i] = pgu_pkg::PROB_HALF;
    reg_len = pgu_pkg::RST_STRING_LENGTH;
    reg_eta = pgu_pkg::RST_LEARNING_RATE;
    reg_mu = pgu_pkg::RST_SELECTED_COUNT;
    reg_lb = pgu_pkg::RST_LOWER_BORDER;
    reg_target = pgu_pkg::RST_TARGET_FITNESS;
  endfunction

  function void write_reg(logic [2:0] idx, logic [15:0] val);
    case (idx)
      pgu_pkg::CFG_STRING_LENGTH:  reg_len = val[6:0];
      pgu_pkg::CFG_LEARNING_RATE:  reg_eta = val;
      pgu_pkg::CFG_SELECTED_COUNT: reg_mu = val[6:0];
      pgu_pkg::CFG_LOWER_BORDER:   reg_lb = val[14:0];
      pgu_pkg::CFG_TARGET_FITNESS: reg_target = val[6:0];
      default: ;
    endcase
  endfunction

  function int unsigned pair_fitness(logic [63:0] s, int unsigned len);
    int unsigned f;
    f = 0;
    for (int k = 0; k + 1 < len; k += 2) begin
      if (s[k] && s[k+1]) f += 3;
      else if (s[k] != s[k+1]) return f + 1;
      else return f + 2;
    end
    return f;
  endfunction

  function void note_candidate(logic [63:0] cand, logic last);
    int unsigned len, mu, fill, sc, pos, top, best, lb, ub, cnt;
    longint unsigned p;
    len = reg_len < 2 ? 2 : (reg_len > 64 ? 64 : reg_len);
    len = len & ~1;
    mu = reg_mu < 1 ? 1 : (reg_mu > 64 ? 64 : reg_mu);
    fill = store_fill < mu ? store_fill : mu;
    sc = pair_fitness(cand, len);
    pos = 0;
    while (pos < fill && store_score[pos] > sc) pos++;
    if (pos < mu) begin
      top = fill < mu ? fill : mu - 1;
      for (int j = top; j > pos; j--) begin
        store_bits[j] = store_bits[j-1];
        store_score[j] = store_score[j-1];
      end
      store_bits[pos] = cand;
      store_score[pos] = sc[6:0];
      if (fill < mu) fill++;
    end
    store_fill = fill;
    if (!last) return;
    best = fill > 0 ? store_score[0] : 0;
    lb = reg_lb == 0 ? 1 : reg_lb;
    ub = 65536 - lb;
    for (int i = 0; i < len; i++) begin
      cnt = 0;
      for (int j = 0; j < fill; j++) cnt += store_bits[j][i];
      p = probs[i];
      p = p - ((reg_eta * p) >> 16) + (longint'(reg_eta) * cnt) / mu;
      if (p < lb) p = lb;
      else if (p > ub) p = ub;
      probs[i] = p[15:0];
      pending_results.push_back({6'(i), p[15:0], 7'(best), best == reg_target,
                                 i + 1 == len});
    end
    store_fill = 0;
  endfunction

  function void check_result(logic [5:0] idx, logic [15:0] prob, logic [6:0] best,
                             logic hit, logic last);
    logic [30:0] e;
    if (pending_results.size() == 0) begin
      $error("unexpected result transaction, bit_index %0d", idx);
      errors++;
      return;
    end
    e = pending_results.pop_front();
    if (idx !== e[30:25]) begin
      $error("bit_index expected %0d got %0d", e[30:25], idx); errors++;
    end
    if (prob !== e[24:9]) begin
      $error("probability expected %0d got %0d", e[24:9], prob); errors++;
    end
    if (best !== e[8:2]) begin
      $error("best_score expected %0d got %0d", e[8:2], best); errors++;
    end
    if (hit !== e[1]) begin
      $error("reached_target expected %0d got %0d", e[1], hit); errors++;
    end
    if (last !== e[0]) begin
      $error("model_end expected %0d got %0d", e[0], last); errors++;
    end
  endfunction
endclass

module tb_top;
  import pgu_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [63:0] in_candidate_bits = '0;
  logic        in_final_candidate = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [5:0]  out_bit_index;
  logic [15:0] out_probability;
  logic [6:0]  out_best_score;
  logic        out_reached_target;
  logic        out_model_end;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  pbil_scoreboard prob_board;
  int unsigned idle_cycles = 0;
  // receiver hold-off request, waited out and cleared in the receiver's own process
  int unsigned rx_hold = 0;

  always #5 clk = ~clk;

  pbil_generation_update u_top (.*);

  // Log each accepted candidate into the predictor at the edge it is taken, and check each result taken.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      prob_board.note_candidate(in_candidate_bits, in_final_candidate);
    if (rst_n && out_valid && out_ready)
      prob_board.check_result(out_bit_index, out_probability, out_best_score,
                              out_reached_target, out_model_end);
  end

  // Watchdog: a generation end at L=64 updates every bit position in turn, and
  // receiver stalls on each result lengthen it further; allow plenty.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result receiver: random stall per transaction, plus a long hold on request.
  initial begin
    int unsigned wait_n;
    @(posedge clk iff rst_n);
    forever begin
      if (rx_hold > 0) begin
        out_ready <= 1'b0;
        repeat (rx_hold) @(posedge clk);
        rx_hold = 0;
      end
      wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      if (wait_n > 0) begin
        out_ready <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk iff out_valid);
    end
  end

  task automatic send_candidate(logic [63:0] bits, logic last, bit no_gap = 1'b0);
    int unsigned gap;
    gap = no_gap ? 0 : $urandom_range(0, 11);
    repeat (gap) @(posedge clk);
    in_valid <= 1'b1;
    in_candidate_bits <= bits;
    in_final_candidate <= last;
    @(posedge clk iff in_ready);
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_cfg(logic [2:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk iff cfg_ready);
    prob_board.write_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Wait for every expected result, then let the block settle back to idle.
  task automatic drain();
    while (prob_board.pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Candidates built from a run of 11 pairs then a random stopping pair,
  // so that fitness spreads over the whole range.
  function automatic logic [63:0] shaped_candidate();
    logic [63:0] v;
    int unsigned run;
    v = {$urandom, $urandom};
    run = $urandom_range(0, 32);
    for (int k = 0; k < run; k++) v[2*k +: 2] = 2'b11;
    return v;
  endfunction

  task automatic run_generation(int unsigned n, bit no_gap = 1'b0);
    for (int i = 0; i < n; i++)
      send_candidate(shaped_candidate(), i == n - 1, no_gap);
  endtask

  initial begin
    int unsigned sent;
    prob_board = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: field extremes under reset settings; ties and a full store.
    send_candidate(64'h0, 1'b0);
    send_candidate('1, 1'b0);
    send_candidate(64'h5555_5555_5555_5555, 1'b0);
    send_candidate(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    send_candidate(64'h0000_0000_0000_000F, 1'b0);
    send_candidate(64'h0000_0000_0000_000F, 1'b0);
    for (int i = 0; i < 5; i++) send_candidate({$urandom, $urandom}, 1'b0);
    send_candidate('1, 1'b1);
    drain();
    // Two-candidate generation at the extremes of every register.
    write_cfg(CFG_STRING_LENGTH, 16'd2);
    write_cfg(CFG_LEARNING_RATE, 16'hFFFF);
    write_cfg(CFG_SELECTED_COUNT, 16'd1);
    write_cfg(CFG_LOWER_BORDER, 16'd32767);
    write_cfg(CFG_TARGET_FITNESS, 16'd3);
    send_candidate(64'h3, 1'b0);
    send_candidate(64'h1, 1'b1);
    drain();
    // Out-of-range values: length saturates, odd rounds down, mu and border
    // clamp; the target is missed at 0 and hit at 48.
    write_cfg(CFG_STRING_LENGTH, 16'd127);
    write_cfg(CFG_SELECTED_COUNT, 16'd0);
    write_cfg(CFG_LOWER_BORDER, 16'd0);
    write_cfg(CFG_LEARNING_RATE, 16'd0);
    write_cfg(CFG_TARGET_FITNESS, 16'd0);
    send_candidate(64'h0, 1'b1);
    drain();
    write_cfg(CFG_STRING_LENGTH, 16'd0);
    write_cfg(CFG_SELECTED_COUNT, 16'd127);
    write_cfg(CFG_LOWER_BORDER, 16'd1);
    write_cfg(CFG_LEARNING_RATE, 16'd40000);
    send_candidate(64'h2, 1'b0);
    send_candidate(64'h3, 1'b1);
    drain();
    write_cfg(CFG_STRING_LENGTH, 16'd33);
    write_cfg(CFG_SELECTED_COUNT, 16'd64);
    write_cfg(CFG_TARGET_FITNESS, 16'd48);
    send_candidate({32'h0, 32'hFFFF_FFFF}, 1'b1);
    drain();

    // Random phases with several register settings.
    sent = 0;
    while (sent < 500) begin
      int unsigned n;
      if ($urandom_range(0, 2) == 0)
        write_cfg(CFG_STRING_LENGTH,
                  $urandom_range(0, 1) ? 16'd64 : 16'($urandom_range(0, 127)));
      if ($urandom_range(0, 2) == 0)
        write_cfg(CFG_LEARNING_RATE, 16'($urandom_range(0, 65535)));
      if ($urandom_range(0, 2) == 0)
        write_cfg(CFG_SELECTED_COUNT, 16'($urandom_range(0, 20)));
      if ($urandom_range(0, 3) == 0)
        write_cfg(CFG_LOWER_BORDER, 16'($urandom_range(0, 32767)));
      if ($urandom_range(0, 2) == 0)
        write_cfg(CFG_TARGET_FITNESS, 16'($urandom_range(0, 96)));
      n = $urandom_range(1, 30);
      if (sent > 150 && sent < 190) begin
        // Receiver holds off while the next generation keeps arriving.
        rx_hold = 400;
        run_generation(n, 1'b1);
        run_generation(4, 1'b1);
        sent += 4;
      end else begin
        run_generation(n, $urandom_range(0, 3) == 0);
      end
      sent += n;
      // Sender pauses for the block to drain before reconfiguring.
      drain();
    end

    drain();
    if (prob_board.errors == 0 && prob_board.pending_results.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end
endmodule

/* pbil_generation_update.f */
src/pgu_pkg.sv
src/pgu_divider.sv
src/pgu_datapath.sv
src/pgu_ctrl.sv
src/pbil_generation_update.sv
dv/tb_top.sv
